// ----- hdl/stbs_pkg.sv -----
// Shared types and constants for the sorted table bound search block.
package stbs_pkg;

  localparam int KEY_W  = 64;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int POS_W  = 12;

  typedef enum logic [KIND_W-1:0] {
    KIND_STORE      = 2'd0,
    KIND_LOWER      = 2'd1,
    KIND_UPPER      = 2'd2,
    KIND_LAST_LESS  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_PROBE,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RES_NONE_BELOW,
    RES_PAST_END,
    RES_BRACKET
  } res_sel_e;

  typedef enum logic [1:0] {
    RA_FIRST,
    RA_LAST,
    RA_MID
  } raddr_sel_e;

  typedef struct packed {
    logic       store_wr;
    logic       load_query;
    raddr_sel_e raddr_sel;
    logic       init_bracket;
    logic       step_probe;
    logic       load_res;
    res_sel_e   res_sel;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_store;
    logic count_zero;
    logic accept_hit;
    logic bracket_open;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/stbs_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module stbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/stbs_datapath.sv -----
// Datapath: count register, table RAM, search bracket, result and output registers.
module stbs_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              entries_in_use_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]        entries_in_use_i,
  input  logic [stbs_pkg::KIND_W-1:0]       kind_i,
  input  logic [stbs_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] entry_value_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] search_key_i,
  input  logic                              out_ready_i,
  input  stbs_pkg::ctrl_cmd_t               cmd_i,
  output stbs_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  output logic signed [stbs_pkg::POS_W-1:0] position_o
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CNT_W-1:0]        count_q, count_d;
  kind_e                   kind_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CNT_W-1:0]        l_q, l_d, r_q, r_d, mid_q, mid_d;
  logic [CNT_W-1:0]        mid_hi, mid_lo, last_idx;
  logic [POS_W-1:0]        res_q, res_d;
  logic [POS_W-1:0]        pos_q;
  logic                    out_valid_q;
  logic                    hit;
  logic                    wr_en;
  logic [AW-1:0]           raddr;
  logic [KEY_W-1:0]        rdata;
  logic signed [KEY_W-1:0] entry;

  // config write, saturated to the table depth
  always_comb begin
    count_d = count_q;
    if (entries_in_use_we_i) begin
      if (32'(entries_in_use_i) > TABLE_DEPTH) begin
        count_d = CNT_W'(TABLE_DEPTH);
      end else begin
        count_d = entries_in_use_i;
      end
    end
  end

  assign last_idx = count_q - CNT_W'(1);

  // stores past the depth are dropped
  assign wr_en = cmd_i.store_wr && (32'(entry_index_i) < TABLE_DEPTH);

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i (entry_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign entry = $signed(rdata);

  // upper bound accepts entry <= key, the others entry < key
  assign hit = (kind_q == KIND_UPPER) ? !(key_q < entry) : (entry < key_q);

  // both candidate midpoints, selected by the compare
  assign mid_hi = mid_q + ((r_q - mid_q) >> 1);
  assign mid_lo = l_q + ((mid_q - l_q) >> 1);

  always_comb begin
    l_d   = l_q;
    r_d   = r_q;
    mid_d = mid_q;
    if (cmd_i.init_bracket) begin
      l_d   = '0;
      r_d   = last_idx;
      mid_d = last_idx >> 1;
    end else if (cmd_i.step_probe) begin
      if (hit) begin
        l_d   = mid_q;
        mid_d = mid_hi;
      end else begin
        r_d   = mid_q;
        mid_d = mid_lo;
      end
    end
  end

  always_comb begin
    case (cmd_i.raddr_sel)
      RA_FIRST: raddr = '0;
      RA_LAST:  raddr = AW'(last_idx);
      RA_MID:   raddr = AW'(mid_d);
      default:  raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.res_sel)
      RES_NONE_BELOW: res_d = (kind_q == KIND_LAST_LESS) ? '1 : '0;
      RES_PAST_END:   res_d = (kind_q == KIND_LAST_LESS) ? {1'b0, last_idx}
                                                          : {1'b0, count_q};
      RES_BRACKET:    res_d = (kind_q == KIND_LAST_LESS) ? {1'b0, l_d} : {1'b0, r_d};
      default:        res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      kind_q <= kind_e'(kind_i);
      key_q  <= search_key_i;
    end
    l_q   <= l_d;
    r_q   <= r_d;
    mid_q <= mid_d;
    if (cmd_i.load_res) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      pos_q <= res_q;
    end
  end

  assign status_o.in_is_store  = (kind_e'(kind_i) == KIND_STORE);
  assign status_o.count_zero   = (count_q == '0);
  assign status_o.accept_hit   = hit;
  assign status_o.bracket_open = ({1'b0, l_d} + (CNT_W+1)'(1)) < {1'b0, r_d};
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign position_o  = $signed(pos_q);

endmodule

// ----- hdl/stbs_ctrl.sv -----
// Controller: search sequencing state machine.
module stbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stbs_pkg::dp_status_t status_i,
  output stbs_pkg::ctrl_cmd_t  cmd_o
);
  import stbs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !status_i.in_is_store) begin
          state_d = ST_CHK_FIRST;
        end
      end
      ST_CHK_FIRST: begin
        if (status_i.count_zero || !status_i.accept_hit) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_CHK_LAST;
        end
      end
      ST_CHK_LAST: begin
        if (status_i.accept_hit || !status_i.bracket_open) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!status_i.bracket_open) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.raddr_sel    = RA_FIRST;
    cmd_o.res_sel      = RES_NONE_BELOW;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.store_wr   = in_valid_i && status_i.in_is_store;
        cmd_o.load_query = in_valid_i && !status_i.in_is_store;
      end
      ST_CHK_FIRST: begin
        cmd_o.raddr_sel = RA_LAST;
        if (status_i.count_zero || !status_i.accept_hit) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_NONE_BELOW;
        end
      end
      ST_CHK_LAST: begin
        cmd_o.raddr_sel = RA_MID;
        if (status_i.accept_hit) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_PAST_END;
        end else begin
          cmd_o.init_bracket = 1'b1;
          if (!status_i.bracket_open) begin
            cmd_o.load_res = 1'b1;
            cmd_o.res_sel  = RES_BRACKET;
          end
        end
      end
      ST_PROBE: begin
        cmd_o.raddr_sel  = RA_MID;
        cmd_o.step_probe = 1'b1;
        if (!status_i.bracket_open) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_BRACKET;
        end
      end
      ST_FINISH: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- hdl/sorted_table_bound_search_core.sv -----
// Top level of the sorted table bound search block.
//
//  channel         handshake                     payload
//  --------------  ----------------------------  ------------------------------------------
//  config write    entries_in_use_we_i           entries_in_use_i (11b, saturates to depth)
//  input word      in_valid_i / in_ready_o       kind_i, entry_index_i, entry_value_i,
//                                                search_key_i
//  result word     out_valid_o / out_ready_i     position_o (12b signed, -1 = none)
//
// A store word writes the table RAM on acceptance.
// A query checks the first entry, then the last entry, then runs one midpoint probe per cycle,
// bounded by the single registered RAM read port, stopping once the result is known; the
// result then goes into the output register.
// One query is worked on at a time; the next word is taken once the current query has
// moved its result into the output register, even if that result is still not taken.
// Reset clears the entry count and control state; table contents are not cleared.
module sorted_table_bound_search_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config
  input  logic                              entries_in_use_we_i,
  input  logic [stbs_pkg::CNT_W-1:0]        entries_in_use_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [stbs_pkg::KIND_W-1:0]       kind_i,
  input  logic [stbs_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] entry_value_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] search_key_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [stbs_pkg::POS_W-1:0] position_o
);
  import stbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing: idle -> check first -> check last -> probes -> finish
  stbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table RAM, compare, bracket l/r/mid and output register
  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .entries_in_use_we_i (entries_in_use_we_i),
    .entries_in_use_i    (entries_in_use_i),
    .kind_i              (kind_i),
    .entry_index_i       (entry_index_i),
    .entry_value_i       (entry_value_i),
    .search_key_i        (search_key_i),
    .out_ready_i         (out_ready_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (out_valid_o),
    .position_o          (position_o)
  );

endmodule

// ----- tb/tb_sorted_table_bound_search_core.sv -----
// Self-checking testbench: store and query words checked against a search predictor.
module tb_sorted_table_bound_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int DEPTH         = 1024;
  localparam int CLK_PERIOD    = 20;
  localparam int SETTLE_CYCLES = 24;
  localparam int WORD_BUDGET   = 2000;

  localparam logic signed [KEY_W-1:0] KEY_MIN  = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX  = {1'b0, {(KEY_W-1){1'b1}}};
  // last-less answer when no entry is below the key
  localparam logic signed [POS_W-1:0] POS_NONE = -1;

  // Mirror of the table and entry count; predicts one position per query word and
  // keeps the positions still owed by the block in arrival order.
  class position_tracker;
    logic signed [KEY_W-1:0] entries [DEPTH];
    bit                      loaded  [DEPTH];
    int unsigned             span;
    logic signed [POS_W-1:0] due_q [$];
    int                      errors;

    function new();
      span   = 0;
      errors = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_span(input logic [CNT_W-1:0] v);
      span = (v > DEPTH) ? DEPTH : v;
    endfunction

    function bit prefix_loaded(input int unsigned n);
      for (int i = 0; i < n; i++) if (!loaded[i]) return 1'b0;
      return 1'b1;
    endfunction

    // entry < key, or entry <= key for upper bound
    function bit passes(input logic signed [KEY_W-1:0] entry, input logic signed [KEY_W-1:0] key,
                        input bit incl);
      return incl ? !(key < entry) : (entry < key);
    endfunction

    // Fixed probe order: first entry, last entry, then floor midpoints.
    function logic signed [POS_W-1:0] search_position(input kind_e k,
                                                      input logic signed [KEY_W-1:0] key);
      int unsigned lo, hi, mid;
      bit incl, last;
      incl = (k == KIND_UPPER);
      last = (k == KIND_LAST_LESS);
      if (span == 0 || !passes(entries[0], key, incl)) return last ? POS_NONE : POS_W'(0);
      if (passes(entries[span-1], key, incl)) return last ? POS_W'(span - 1) : POS_W'(span);
      lo = 0;
      hi = span - 1;
      while (lo + 1 < hi) begin
        mid = lo + (hi - lo) / 2;
        if (passes(entries[mid], key, incl)) lo = mid;
        else hi = mid;
      end
      return last ? POS_W'(lo) : POS_W'(hi);
    endfunction

    task report(input string msg);
      errors++;
      $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Called for every accepted input word. Every index fits the table at this depth.
    task take_word(input kind_e k, input logic [IDX_W-1:0] idx,
                   input logic signed [KEY_W-1:0] val, input logic signed [KEY_W-1:0] key);
      if (k == KIND_STORE) begin
        entries[idx] = val;
        loaded[idx]  = 1'b1;
      end else begin
        due_q.push_back(search_position(k, key));
      end
    endtask

    task check_position(input logic signed [POS_W-1:0] got);
      logic signed [POS_W-1:0] want;
      if (due_q.size() == 0) begin
        report($sformatf("position %0d with no query outstanding", got));
        return;
      end
      want = due_q.pop_front();
      if (got !== want) report($sformatf("position %0d, expected %0d", got, want));
    endtask
  endclass

  position_tracker tracker = new();

  logic                     clk_i               = 1'b0;
  logic                     rst_ni              = 1'b0;
  logic                     entries_in_use_we_i = 1'b0;
  logic [CNT_W-1:0]         entries_in_use_i    = '0;
  logic                     in_valid_i          = 1'b0;
  logic                     in_ready_o;
  logic [KIND_W-1:0]        kind_i              = '0;
  logic [IDX_W-1:0]         entry_index_i       = '0;
  logic signed [KEY_W-1:0]  entry_value_i       = '0;
  logic signed [KEY_W-1:0]  search_key_i        = '0;
  logic                     out_valid_o;
  logic                     out_ready_i         = 1'b0;
  logic signed [POS_W-1:0]  position_o;

  sorted_table_bound_search_core #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .entries_in_use_we_i (entries_in_use_we_i),
    .entries_in_use_i    (entries_in_use_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .entry_index_i       (entry_index_i),
    .entry_value_i       (entry_value_i),
    .search_key_i        (search_key_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .position_o          (position_o)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  // Hard stop, roughly ten times the slowest legal run.
  initial begin
    #(20ms);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: check each taken word, then pick next cycle's ready.
  // Stall mode is redrawn at random from time to time: always ready, mostly
  // ready, mostly stalled, or long periodic stalls.
  // ---------------------------------------------------------------------------
  int unsigned rx_cycle = 0;
  int unsigned rx_mode  = 0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_position(position_o);
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    rx_cycle++;
    case (rx_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_ready_i <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready_i <= ((rx_cycle % 19) > 13);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side. Words go out in bursts; between bursts valid drops for a
  // random gap. Within a burst valid stays high from word to word.
  // ---------------------------------------------------------------------------
  int          burst_left = 0;
  int unsigned words_sent = 0;

  function automatic logic signed [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Call at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input kind_e k, input logic [IDX_W-1:0] idx,
                           input logic signed [KEY_W-1:0] val,
                           input logic signed [KEY_W-1:0] key);
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 30);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    entry_index_i <= idx;
    entry_value_i <= val;
    search_key_i  <= key;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_word(k, idx, val, key);
    burst_left--;
    words_sent++;
  endtask

  // Queries carry junk in the store-only fields.
  task automatic send_query(input kind_e k, input logic signed [KEY_W-1:0] key);
    send_word(k, IDX_W'($urandom), rand_key(), key);
  endtask

  // Drain: nothing owed, then let a trailing query or store finish inside.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_span(input int unsigned v);
    entries_in_use_we_i <= 1'b1;
    entries_in_use_i    <= CNT_W'(v);
    @(posedge clk_i);
    tracker.set_span(CNT_W'(v));
    entries_in_use_we_i <= 1'b0;
  endtask

  // Fill entries 0..n-1 in ascending order; steps are tiny (duplicates),
  // 32-bit, or wide. Overflow clamps to the max key so order holds.
  task automatic load_ascending(input int unsigned n, input bit wide);
    logic signed [KEY_W-1:0] v, nxt, step;
    int unsigned mode, shift;
    v     = ($urandom_range(0, 3) == 0) ? KEY_MIN : rand_key();
    mode  = wide ? 2 : $urandom_range(0, 2);
    shift = wide ? 11 : $urandom_range(1, 8);
    if (wide && v > 0) v = -v;
    for (int i = 0; i < n; i++) begin
      send_word(KIND_STORE, IDX_W'(i), v, rand_key());
      case (mode)
        0:       step = $urandom_range(0, 3);
        1:       step = $urandom;
        default: step = {$urandom, $urandom} >> shift;
      endcase
      nxt = v + step;
      if (nxt < v) nxt = KEY_MAX;
      v = nxt;
    end
  endtask

  // Mostly keys near stored entries so the probes go deep; some extremes,
  // some random keys, and about one word in ten a stray store.
  task automatic run_queries(input int unsigned nq);
    int unsigned n, pick;
    logic signed [KEY_W-1:0] key;
    kind_e k;
    n = tracker.span;
    repeat (nq) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(KIND_STORE, IDX_W'($urandom), rand_key(), rand_key());
      end else begin
        k    = kind_e'($urandom_range(1, 3));
        pick = $urandom_range(0, 9);
        if (n != 0 && pick < 6) begin
          key = tracker.entries[$urandom_range(0, n - 1)];
          case ($urandom_range(0, 2))
            0: key = key - 1;
            2: key = key + 1;
            default: ;
          endcase
        end else if (pick == 6) begin
          key = KEY_MIN;
        end else if (pick == 7) begin
          key = KEY_MAX;
        end else begin
          key = rand_key();
        end
        send_query(k, key);
      end
    end
  endtask

  // One setting of the count. Small tables are reloaded sorted each time;
  // big ones reuse the table once every entry has been written.
  task automatic run_phase(input int unsigned cfg, input int unsigned nq);
    int unsigned n;
    settle();
    write_span(cfg);
    n = (cfg > DEPTH) ? DEPTH : cfg;
    if (n <= 64 || !tracker.prefix_loaded(n)) load_ascending(n, n > 64);
    run_queries(nq);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r, cfg;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Empty table straight out of reset: the count is zero, so no entry decides the result.
    send_query(KIND_LOWER, KEY_MAX);
    send_query(KIND_UPPER, KEY_MIN);
    send_query(KIND_LAST_LESS, KEY_MAX);

    // Five entries with both key extremes and a duplicate pair, plus the top
    // table slot. Stores carry junk keys.
    send_word(KIND_STORE, 0, KEY_MIN, rand_key());
    send_word(KIND_STORE, 1, -64'sd5, rand_key());
    send_word(KIND_STORE, 2, -64'sd5, rand_key());
    send_word(KIND_STORE, 3, 64'sd7, rand_key());
    send_word(KIND_STORE, 4, KEY_MAX, rand_key());
    send_word(KIND_STORE, '1, rand_key(), rand_key());
    settle();
    write_span(5);
    send_query(KIND_LOWER, KEY_MIN);       // before the first entry
    send_query(KIND_UPPER, KEY_MAX);       // past the end
    send_query(KIND_LAST_LESS, KEY_MIN);   // nothing below
    send_query(KIND_LOWER, -64'sd5);       // first of the duplicates
    send_query(KIND_UPPER, -64'sd5);       // just after the duplicates
    send_query(KIND_LAST_LESS, -64'sd5);
    send_query(KIND_LAST_LESS, KEY_MAX);
    send_query(KIND_LOWER, 64'sd7);
    send_query(KIND_UPPER, 64'sd0);
    send_query(KIND_LAST_LESS, 64'sd7);

    // Single entry: first and last checks hit the same slot.
    settle();
    write_span(1);
    send_query(KIND_LOWER, 64'sd0);
    send_query(KIND_LAST_LESS, KEY_MAX);

    // Full sorted table, then the same table with the count saturating.
    run_phase(DEPTH, 150);
    run_phase(2**CNT_W - 1, 60);

    while (words_sent < WORD_BUDGET) begin
      r = $urandom_range(0, 19);
      case (r)
        0:       cfg = 0;
        1:       cfg = 1;
        2:       cfg = DEPTH;
        3:       cfg = 2**CNT_W - 1;
        4:       cfg = $urandom_range(DEPTH + 1, 2**CNT_W - 2);
        default: cfg = $urandom_range(2, 48);
      endcase
      run_phase(cfg, $urandom_range(20, 40));
    end

    settle();
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/stbs_datapath.sv
hdl/stbs_ctrl.sv
hdl/sorted_table_bound_search_core.sv
tb/tb_sorted_table_bound_search_core.sv
